/* rtl/core/rbf_gram_matrix_lower_triangle_core_assert.svh */
// Assertion macros for the RBF Gram matrix core.
// Depends on a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef RBF_GRAM_MATRIX_LOWER_TRIANGLE_CORE_ASSERT_SVH
`define RBF_GRAM_MATRIX_LOWER_TRIANGLE_CORE_ASSERT_SVH

// same-cycle implication
`define RBF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbf core assertion failed");

// next-cycle implication
`define RBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbf core assertion failed");

`endif

/* rtl/core/rbf_pkg.sv */
// Constants and helper function for the RBF Gram matrix core.
// No dependencies.
package rbf_pkg;

    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [26:0] LOG2E_Q26 = 27'd96817625;
    localparam logic [63:0] ONE_Q32   = 64'd4294967296;

    localparam logic [1:0] CFG_GAMMA        = 2'd0;
    localparam logic [1:0] CFG_NUM_POINTS   = 2'd1;
    localparam logic [1:0] CFG_NUM_FEATURES = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef logic [32:0] t_exp_word;

    // exp(-u) in Q.32 by a Taylor series through the u^13 term, evaluated at elaboration
    function automatic t_exp_word exp_neg_q32(input logic [63:0] u);
        logic signed [65:0] sum;
        logic [63:0]        term;
        sum  = 66'(ONE_Q32);
        term = ONE_Q32;
        for (int n = 1; n <= 13; n++) begin
            term = ((term * u) >> 32) / 64'(n);
            if ((n % 2) == 1) begin
                sum = sum - 66'(term);
            end else begin
                sum = sum + 66'(term);
            end
        end
        return t_exp_word'(sum);
    endfunction

endpackage

/* rtl/core/rbf_gram_matrix_lower_triangle_core.sv */
// RBF Gram matrix core: feature store, shared multiplier sequencer, exp table.
// Depends on rbf_pkg and rbf_gram_matrix_lower_triangle_core_assert.svh.
//
// Input stream: tuser is the command (0 load, 1 emit column). A load writes
// one Q8.8 feature of one point into the feature store.
// An emit for column j returns rows j .. num_points-1 as output transfers,
// tlast on the final row. For each row the squared distance runs through one
// shared 32x32 multiplier, one feature per cycle with both feature reads from
// the two-read-port store, then gamma scaling and the log2(e) product reuse
// the same multiplier over four more steps, followed by an exp table lookup
// and a rounding shift.
// The input side is ready only while the sequencer is idle.
// The output register holds a result until it is taken; when the receiver
// stalls the sequencer waits before loading the next row.
// Reset (synchronous, active low) clears the control state and sets gamma to
// 1.0, num_points and num_features to 64. The store is undefined until
// written; the exp table is a constant ROM with registered read.
// Configuration writes are taken at any cycle and must happen while idle.
module rbf_gram_matrix_lower_triangle_core
    import rbf_pkg::*;
#(
    parameter int MAX_POINTS        = 64,
    parameter int MAX_FEATURES      = 64,
    parameter int EXP_TABLE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] point_index, [11:6] feature_index, [27:12] feature_value, [31:28] zero
    input  logic [31:0] s_axis_tdata,
    // [0] command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] row_index, [11:6] column_index, [27:12] kernel_value, [31:28] zero
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int PIW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FCW   = $clog2(MAX_FEATURES + 1);
    localparam int DEPTH = MAX_POINTS * MAX_FEATURES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = 32 + $clog2(MAX_FEATURES + 1);
    localparam int IW    = $clog2(EXP_TABLE_ENTRIES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIST  = 4'd1;
    localparam logic [3:0] ST_G_LO  = 4'd2;
    localparam logic [3:0] ST_G_HI  = 4'd3;
    localparam logic [3:0] ST_G_SUM = 4'd4;
    localparam logic [3:0] ST_L_HI  = 4'd5;
    localparam logic [3:0] ST_L_LO  = 4'd6;
    localparam logic [3:0] ST_T_SUM = 4'd7;
    localparam logic [3:0] ST_ROM   = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    typedef t_exp_word t_rom [EXP_TABLE_ENTRIES];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] u;
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
            u = (64'(k) * LN2_Q32) / 64'(EXP_TABLE_ENTRIES);
            rom[k] = exp_neg_q32(u);
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();

    logic [15:0] r_store [DEPTH];

    logic [3:0]     r_state, n_state;
    logic [31:0]    r_gamma;
    logic [6:0]     r_num_points;
    logic [6:0]     r_num_features;
    logic [PIW-1:0] r_row, r_col;
    logic [FCW-1:0] r_feat;
    logic           r_v1, r_v2;
    logic [15:0]    r_rd_i, r_rd_j;
    logic [63:0]    r_prod;
    logic [DW-1:0]  r_acc;
    logic [63:0]    r_plo;
    logic [36:0]    r_a;
    logic           r_zero;
    logic [38:0]    r_t;
    t_exp_word      r_m;
    logic           r_out_valid;
    logic [31:0]    r_out_data;
    logic           r_out_last;

    logic [6:0]     w_np, w_nf;
    logic [31:0]    w_mul_a, w_mul_b;
    logic           w_in_fire, w_out_free;
    logic [5:0]     w_pt, w_fi;
    logic [AW-1:0]  w_addr_i, w_addr_j, w_waddr;
    logic           w_issue;
    logic signed [16:0] w_diff;
    logic [15:0]    w_absd;
    logic [71:0]    w_p;
    logic [64:0]    w_tfull;
    logic [44:0]    w_idx_prod;
    logic [IW-1:0]  w_idx;
    logic [6:0]     w_n;
    logic [33:0]    w_rnd_sum;
    logic [33:0]    w_shifted;
    logic [15:0]    w_kernel;
    logic           w_last_row;

    assign w_np = (r_num_points > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : r_num_points;
    assign w_nf = (r_num_features > 7'(MAX_FEATURES)) ? 7'(MAX_FEATURES) : r_num_features;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_pt          = s_axis_tdata[5:0];
    assign w_fi          = s_axis_tdata[11:6];
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_last_row    = (7'(r_row) == w_np - 7'd1);

    assign w_issue  = (r_state == ST_DIST) && (7'(r_feat) < w_nf);
    assign w_addr_i = AW'(r_row) * AW'(MAX_FEATURES) + AW'(r_feat);
    assign w_addr_j = AW'(r_col) * AW'(MAX_FEATURES) + AW'(r_feat);
    assign w_waddr  = AW'(w_pt) * AW'(MAX_FEATURES) + AW'(w_fi);

    assign w_diff = $signed({r_rd_i[15], r_rd_i}) - $signed({r_rd_j[15], r_rd_j});
    assign w_absd = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            ST_G_LO: begin
                w_mul_a = r_gamma;
                w_mul_b = r_acc[31:0];
            end
            ST_G_HI: begin
                w_mul_a = r_gamma;
                w_mul_b = 32'(r_acc >> 32);
            end
            ST_L_HI: begin
                w_mul_a = 32'(r_a[36:20]);
                w_mul_b = 32'(LOG2E_Q26);
            end
            ST_L_LO: begin
                w_mul_a = 32'(r_a[19:0]);
                w_mul_b = 32'(LOG2E_Q26);
            end
            default: begin
                w_mul_a = 32'(w_absd);
                w_mul_b = 32'(w_absd);
            end
        endcase
    end

    assign w_p        = 72'(r_plo) + (72'(r_prod) << 32);
    assign w_tfull    = (65'(r_plo) << 20) + 65'(r_prod);
    assign w_idx_prod = 45'(r_t[31:0]) * 45'(EXP_TABLE_ENTRIES);
    assign w_idx      = w_idx_prod[32 +: IW];
    assign w_n        = r_t[38:32];
    assign w_rnd_sum  = 34'(r_m) + (34'd1 << (w_n + 7'd15));
    assign w_shifted  = w_rnd_sum >> (w_n + 7'd16);
    assign w_kernel   = (r_zero || w_n >= 7'd17) ? 16'd0 :
                        (w_shifted > 34'd65535) ? 16'hFFFF : w_shifted[15:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && s_axis_tuser == CMD_EMIT && 7'(w_pt) < w_np) begin
                    n_state = ST_DIST;
                end
            end
            ST_DIST: begin
                if (7'(r_feat) >= w_nf && !r_v1 && !r_v2) begin
                    n_state = ST_G_LO;
                end
            end
            ST_G_LO:  n_state = ST_G_HI;
            ST_G_HI:  n_state = ST_G_SUM;
            ST_G_SUM: n_state = ST_L_HI;
            ST_L_HI:  n_state = ST_L_LO;
            ST_L_LO:  n_state = ST_T_SUM;
            ST_T_SUM: n_state = ST_ROM;
            ST_ROM:   n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = w_last_row ? ST_IDLE : ST_DIST;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // feature store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_in_fire && s_axis_tuser == CMD_LOAD &&
            7'(w_pt) < 7'(MAX_POINTS) && 7'(w_fi) < 7'(MAX_FEATURES)) begin
            r_store[w_waddr] <= s_axis_tdata[27:12];
        end
        r_rd_i <= r_store[w_addr_i];
        r_rd_j <= r_store[w_addr_j];
    end

    always_ff @(posedge i_clk) begin
        r_m <= EXP_ROM[w_idx];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_mul_a) * 64'(w_mul_b);
        if (r_state == ST_IDLE) begin
            r_row <= PIW'(w_pt);
            r_col <= PIW'(w_pt);
        end else if (r_state == ST_FIN && w_out_free) begin
            r_row <= r_row + PIW'(1);
        end
        // clear before each row; hold through the gamma steps
        if (r_state == ST_IDLE || r_state == ST_FIN) begin
            r_acc <= '0;
        end else if (r_state == ST_DIST && r_v2) begin
            r_acc <= r_acc + DW'(r_prod);
        end
        if (r_state == ST_G_HI) begin
            r_plo <= r_prod;
        end else if (r_state == ST_L_LO) begin
            r_plo <= r_prod;
        end
        if (r_state == ST_G_SUM) begin
            r_zero <= (w_p[71:47] != '0);
            r_a    <= w_p[46:10];
        end
        if (r_state == ST_T_SUM) begin
            r_t <= w_tfull[64:26];
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_out_data <= {4'd0, w_kernel, 6'(r_col), 6'(r_row)};
            r_out_last <= w_last_row;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_gamma        <= 32'd67108864;
            r_num_points   <= 7'd64;
            r_num_features <= 7'd64;
            r_feat         <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAMMA:        r_gamma        <= i_cfg_wdata;
                    CFG_NUM_POINTS:   r_num_points   <= i_cfg_wdata[6:0];
                    CFG_NUM_FEATURES: r_num_features <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (r_state == ST_DIST) begin
                if (w_issue) begin
                    r_feat <= r_feat + FCW'(1);
                end
            end else begin
                r_feat <= '0;
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`include "rbf_gram_matrix_lower_triangle_core_assert.svh"

    `RBF_ASSERT_NOW(a_lower_triangle, m_axis_tvalid, m_axis_tdata[5:0] >= m_axis_tdata[11:6])
    `RBF_ASSERT_NEXT(a_last_to_idle, r_state == ST_FIN && w_out_free && w_last_row, r_state == ST_IDLE)
    `RBF_ASSERT_NOW(a_pipe_in_dist, r_v1 || r_v2, r_state == ST_DIST || r_state == ST_G_LO)

endmodule

/* tb/rbf_gram_matrix_lower_triangle_core_checker.sv */
// Checker for the RBF Gram matrix core: watches config writes and both streams,
// predicts each kernel entry and compares it with the output transfers.
// Depends on rbf_pkg for command and register codes.
module rbf_gram_matrix_lower_triangle_core_checker
    import rbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,
    input  logic        i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_last,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_entries_seen
);

    typedef struct packed {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [15:0] kval;
        logic        last;
    } kernel_entry_t;

    localparam int NPTS  = 64;
    localparam int NFEAT = 64;
    localparam int NEXP  = 1024;
    localparam longint unsigned LOG2E = 64'd96817625;
    localparam longint unsigned LN2   = 64'd2977044472;
    localparam longint unsigned ONE   = 64'd4294967296;

    kernel_entry_t    entry_fifo[$];
    logic [31:0]      gamma_q;
    logic [6:0]       points_q;
    logic [6:0]       features_q;
    logic [15:0]      features[NPTS*NFEAT];
    longint unsigned  pow2_frac[NEXP];

    // 2^(-k/NEXP) in Q.32 via truncated series for exp(-u)
    function automatic longint unsigned exp_series(input longint unsigned u);
        longint          acc;
        longint unsigned t;
        acc = longint'(ONE);
        t   = ONE;
        for (int n = 1; n <= 13; n++) begin
            t = ((t * u) >> 32) / longint'(n);
            if (n % 2 == 1) acc = acc - longint'(t);
            else            acc = acc + longint'(t);
        end
        return longint'(acc);
    endfunction

    function automatic logic [15:0] rbf_value(input int i, input int j, input int nf);
        longint unsigned d, g, hi, p, a, t, m, v;
        int              n, idx, df;
        d = 0;
        g = {32'd0, gamma_q};
        for (int f = 0; f < nf; f++) begin
            df = int'($signed(features[i*NFEAT+f])) - int'($signed(features[j*NFEAT+f]));
            if (df < 0) df = -df;
            d += longint'(df) * longint'(df);
        end
        hi = g * (d >> 32);
        if (hi >= 64'd32768) return 16'd0;
        p = g * (d & 64'hFFFF_FFFF);
        if (p >= (64'd1 << 47)) return 16'd0;
        p += hi << 32;
        if (p >= (64'd1 << 47)) return 16'd0;
        a = p >> 10;
        t = (a * LOG2E) >> 26;
        n = int'(t >> 32);
        if (n >= 17) return 16'd0;
        idx = int'(((t & 64'hFFFF_FFFF) * NEXP) >> 32);
        if (idx >= NEXP) idx = NEXP - 1;
        m = pow2_frac[idx];
        v = (m + (64'd1 << (n + 15))) >> (n + 16);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic predict_column(input int j);
        int np, nf;
        kernel_entry_t e;
        np = (points_q > NPTS) ? NPTS : int'(points_q);
        nf = (features_q > NFEAT) ? NFEAT : int'(features_q);
        for (int i = j; i < np; i++) begin
            e.row  = i[5:0];
            e.col  = j[5:0];
            e.kval = rbf_value(i, j, nf);
            e.last = (i == np - 1);
            entry_fifo = {entry_fifo, e};
        end
    endtask

    initial begin
        for (int k = 0; k < NEXP; k++)
            pow2_frac[k] = exp_series((longint'(k) * LN2) / NEXP);
        o_mismatches   = 0;
        o_entries_seen = 0;
    end

    always @(posedge i_clk) begin
        kernel_entry_t want;
        if (!i_rst_n) begin
            gamma_q    = 32'h0400_0000;
            points_q   = 7'd64;
            features_q = 7'd64;
            entry_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAMMA:        gamma_q    = i_cfg_wdata;
                    CFG_NUM_POINTS:   points_q   = i_cfg_wdata[6:0];
                    CFG_NUM_FEATURES: features_q = i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_entries_seen++;
                if (entry_fifo.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("unexpected output transfer data=%h last=%b",
                                 i_out_data, i_out_last);
                end else begin
                    want = entry_fifo.pop_front();
                    if (i_out_data[5:0] !== want.row || i_out_data[11:6] !== want.col ||
                        i_out_data[27:12] !== want.kval || i_out_data[31:28] !== 4'd0 ||
                        i_out_last !== want.last) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("mismatch exp row=%0d col=%0d k=%0d last=%b, got row=%0d col=%0d k=%0d last=%b",
                                     want.row, want.col, want.kval, want.last,
                                     i_out_data[5:0], i_out_data[11:6],
                                     i_out_data[27:12], i_out_last);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_user == CMD_LOAD)
                    features[int'(i_in_data[5:0])*NFEAT + int'(i_in_data[11:6])] =
                        i_in_data[27:12];
                else
                    predict_column(int'(i_in_data[5:0]));
            end
        end
        o_pending = entry_fifo.size();
    end

endmodule

/* tb/rbf_gram_matrix_lower_triangle_core_tb.sv */
// Testbench top for the RBF Gram matrix core: clock, reset, config writes,
// feature loads and column emits with random flow control; verdict from the checker.
// Depends on rbf_pkg, the core and rbf_gram_matrix_lower_triangle_core_checker.
module rbf_gram_matrix_lower_triangle_core_tb;
    import rbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int ITEM_TARGET    = 140;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_GAMMA;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = CMD_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    int  mismatches, pending, entries_seen;
    int  items_sent = 0;
    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  long_hold_req = 1'b0;
    bit  loaded[64][64];

    always #2 i_clk = ~i_clk;

    rbf_gram_matrix_lower_triangle_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    rbf_gram_matrix_lower_triangle_core_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_last(m_axis_tlast),
        .o_mismatches(mismatches), .o_pending(pending), .o_entries_seen(entries_seen)
    );

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d entries still expected", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall pattern, quiet stretches, one long hold-off on request
    initial begin
        int mode, len;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(1, 40);
                repeat (len) begin
                    m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off until every expected entry is out, then let the core settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || !s_axis_tready);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send(input logic cmd, input logic [5:0] pt, input logic [5:0] fi,
                        input logic [15:0] val);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'd0, val, fi, pt};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (cmd == CMD_LOAD) loaded[pt][fi] = 1'b1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic load(input int pt, input int fi, input logic [15:0] val);
        send(CMD_LOAD, pt[5:0], fi[5:0], val);
    endtask

    task automatic emit(input int col);
        send(CMD_EMIT, col[5:0], 6'($urandom), 16'($urandom));
    endtask

    function automatic logic [15:0] pick_feature();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    function automatic logic [31:0] pick_gamma();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom_range(0, 32'h0800_0000);
        endcase
    endfunction

    initial begin
        int np, nf, phases, stall_phase;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of features, matching and far-apart points
        write_reg(CFG_NUM_POINTS, 32'd4);
        write_reg(CFG_NUM_FEATURES, 32'd3);
        load(0, 0, 16'h8000); load(0, 1, 16'h7FFF); load(0, 2, 16'h0000);
        load(1, 0, 16'h8000); load(1, 1, 16'h7FFF); load(1, 2, 16'h0000);
        load(2, 0, 16'h0100); load(2, 1, 16'hFF00); load(2, 2, 16'h0080);
        load(3, 0, 16'h7FFF); load(3, 1, 16'h8000); load(3, 2, 16'h0001);
        for (int j = 0; j < 5; j++) emit(j);   // column 4 is out of range
        drain();
        write_reg(CFG_NUM_FEATURES, 32'd0);    // zero features: all ones
        emit(0);
        drain();
        write_reg(CFG_NUM_FEATURES, 32'd3);
        write_reg(CFG_GAMMA, 32'h0);
        emit(1);
        drain();
        write_reg(CFG_GAMMA, 32'hFFFF_FFFF);
        emit(2);
        drain();
        write_reg(CFG_NUM_POINTS, 32'd0);      // no points: no result
        emit(0);
        drain();
        write_reg(CFG_NUM_POINTS, 32'd1);
        write_reg(CFG_GAMMA, 32'h0400_0000);
        emit(0);
        drain();

        // both registers above the cap: column 63 with all 64 features
        write_reg(CFG_NUM_POINTS, 32'h7F);
        write_reg(CFG_NUM_FEATURES, 32'h7F);
        for (int f = 0; f < 64; f++) load(63, f, pick_feature());
        emit(63);
        drain();

        // random phases of small matrices
        phases = 0;
        stall_phase = 2;
        while (items_sent < ITEM_TARGET || phases < 4) begin
            np = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : $urandom_range(2, 5);
            nf = $urandom_range(1, 4);
            write_reg(CFG_NUM_POINTS, 32'(np));
            write_reg(CFG_NUM_FEATURES, 32'(nf));
            write_reg(CFG_GAMMA, pick_gamma());
            for (int p = 0; p < np; p++)
                for (int f = 0; f < nf; f++)
                    if (!loaded[p][f] || $urandom_range(0, 1)) load(p, f, pick_feature());
            if ($urandom_range(0, 2) == 0)
                load($urandom_range(np, 63), $urandom_range(0, 63), pick_feature());
            if (phases == stall_phase) long_hold_req = 1'b1;
            for (int e = 0; e < np + 1; e++)
                emit(($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, np - 1));
            s_axis_tvalid <= 1'b0;
            drain();
            phases++;
        end

        s_axis_tvalid <= 1'b0;
        drain();
        $display("covered %0d input transfers over %0d random phases, %0d kernel entries",
                 items_sent, phases, entries_seen);
        $display("register caps, zero features, gamma extremes and column range checked");
        if (mismatches == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // the checker only reads entries that stimulus has written
    initial begin
        for (int p = 0; p < 64; p++)
            for (int f = 0; f < 64; f++)
                loaded[p][f] = 1'b0;
    end

endmodule
